>>> sv/rmeu_pkg.sv
// rmeu_pkg: types, opcodes, error codes and cost constants of the register machine execute unit
// no dependencies; imported by the interfaces, rmeu_exec and the core

package rmeu_pkg;

  localparam int DATA_W = 64;
  localparam int REG_W  = 3;
  localparam int PC_W   = 11;
  localparam int TGT_W  = 10;
  localparam int OUT_PC_W = 10;
  localparam int COST_W = 63;
  localparam int PLEN_W = 11;
  localparam int OP_W   = 4;
  localparam int ERR_W  = 2;
  localparam int CST_W  = 7;

  localparam logic [PLEN_W-1:0] PLEN_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_HALT  = 4'd0,
    OP_GET   = 4'd1,
    OP_PUT   = 4'd2,
    OP_LOAD  = 4'd3,
    OP_STORE = 4'd4,
    OP_COPY  = 4'd5,
    OP_ADD   = 4'd6,
    OP_SUB   = 4'd7,
    OP_HALF  = 4'd8,
    OP_INC   = 4'd9,
    OP_DEC   = 4'd10,
    OP_JUMP  = 4'd11,
    OP_JZERO = 4'd12,
    OP_JODD  = 4'd13
  } op_t;

  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_PC   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ADDR = 2'd2;

  localparam logic [CST_W-1:0] COST_IO   = 7'd100;
  localparam logic [CST_W-1:0] COST_MEM  = 7'd50;
  localparam logic [CST_W-1:0] COST_ALU  = 7'd5;
  localparam logic [CST_W-1:0] COST_STEP = 7'd1;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [REG_W-1:0]  reg_first;
    logic [REG_W-1:0]  reg_second;
    logic [TGT_W-1:0]  jump_target;
    logic [DATA_W-1:0] get_value;
  } instr_t;

  typedef struct packed {
    logic              rf_we;
    logic [REG_W-1:0]  rf_addr;
    logic [DATA_W-1:0] rf_data;
    logic              mem_we;
    logic [PC_W-1:0]   pc_next;
    logic              put_valid;
    logic [DATA_W-1:0] put_value;
    logic              halted;
    logic [ERR_W-1:0]  err;
    logic [COST_W-1:0] cost_next;
  } exec_t;

endpackage

>>> sv/rmeu_in_if.sv
// rmeu_in_if: instruction channel, valid/ready plus the fetched instruction fields
// depends on rmeu_pkg

interface rmeu_in_if;
  import rmeu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [REG_W-1:0]         reg_first;
  logic [REG_W-1:0]         reg_second;
  logic [TGT_W-1:0]         jump_target;
  logic signed [DATA_W-1:0] get_value;

  modport source (output valid, opcode, reg_first, reg_second, jump_target, get_value,
                  input ready);
  modport sink (input valid, opcode, reg_first, reg_second, jump_target, get_value,
                output ready);
endinterface

>>> sv/rmeu_out_if.sv
// rmeu_out_if: result channel, valid/ready plus pc, put, halt, error and cost fields
// depends on rmeu_pkg

interface rmeu_out_if;
  import rmeu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OUT_PC_W-1:0]      next_pc;
  logic                     put_valid;
  logic signed [DATA_W-1:0] put_value;
  logic                     halted;
  logic [ERR_W-1:0]         error_code;
  logic [COST_W-1:0]        cost_total;

  modport source (output valid, next_pc, put_valid, put_value, halted, error_code,
                  cost_total, input ready);
  modport sink (input valid, next_pc, put_valid, put_value, halted, error_code,
                cost_total, output ready);
endinterface

>>> sv/rmeu_exec.sv
// rmeu_exec: combinational execute step for one instruction
// depends on rmeu_pkg; operands come from the core's register file and data memory reads

module rmeu_exec import rmeu_pkg::*; (
  input  instr_t            ins,
  input  logic              halted,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  input  logic [DATA_W-1:0] load_data,
  input  logic              addr_ok,
  input  logic [PC_W-1:0]   pc,
  input  logic [PC_W-1:0]   limit,
  input  logic [COST_W-1:0] cost,
  output exec_t             res
);

  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] diff;
  logic [PC_W:0]     nxt;
  logic [PC_W:0]     pc_inc;
  logic [CST_W-1:0]  c;
  logic [COST_W:0]   csum;
  logic [ERR_W-1:0]  err;

  assign sum    = a + b;
  assign diff   = a - b;
  assign pc_inc = {1'b0, pc} + (PC_W+1)'(1);

  always_comb begin
    res           = '0;
    res.rf_addr   = ins.reg_first;
    res.pc_next   = pc;
    res.cost_next = cost;
    res.halted    = halted;
    nxt           = {1'b0, pc};
    c             = '0;
    err           = ERR_NONE;
    csum          = '0;
    if (!halted) begin
      case (ins.opcode)
        OP_HALT: begin
          res.halted = 1'b1;
        end
        OP_GET: begin
          res.rf_we = 1'b1; res.rf_data = ins.get_value; c = COST_IO; nxt = pc_inc;
        end
        OP_PUT: begin
          res.put_valid = 1'b1; res.put_value = a; c = COST_IO; nxt = pc_inc;
        end
        OP_LOAD: begin
          res.rf_we = addr_ok; res.rf_data = load_data;
          if (!addr_ok) err = ERR_ADDR;
          c = COST_MEM; nxt = pc_inc;
        end
        OP_STORE: begin
          res.mem_we = addr_ok;
          if (!addr_ok) err = ERR_ADDR;
          c = COST_MEM; nxt = pc_inc;
        end
        OP_COPY: begin
          res.rf_we = 1'b1; res.rf_data = b; c = COST_ALU; nxt = pc_inc;
        end
        OP_ADD: begin
          res.rf_we = 1'b1; res.rf_data = sum; c = COST_ALU; nxt = pc_inc;
        end
        OP_SUB: begin
          // clamps at zero when b is larger
          res.rf_we   = 1'b1;
          res.rf_data = ($signed(a) >= $signed(b)) ? diff : '0;
          c = COST_ALU; nxt = pc_inc;
        end
        OP_HALF: begin
          res.rf_we = 1'b1; res.rf_data = {a[DATA_W-1], a[DATA_W-1:1]};
          c = COST_STEP; nxt = pc_inc;
        end
        OP_INC: begin
          res.rf_we = 1'b1; res.rf_data = a + DATA_W'(1); c = COST_STEP; nxt = pc_inc;
        end
        OP_DEC: begin
          res.rf_we   = 1'b1;
          res.rf_data = ($signed(a) > 0) ? a - DATA_W'(1) : a;
          c = COST_STEP; nxt = pc_inc;
        end
        OP_JUMP: begin
          nxt = (PC_W+1)'(ins.jump_target); c = COST_STEP;
        end
        OP_JZERO: begin
          nxt = (a == '0) ? (PC_W+1)'(ins.jump_target) : pc_inc; c = COST_STEP;
        end
        OP_JODD: begin
          nxt = a[0] ? (PC_W+1)'(ins.jump_target) : pc_inc; c = COST_STEP;
        end
        default: begin
          nxt = {1'b0, pc};
        end
      endcase
      // saturating cost, the sum cannot pass the top bit
      csum          = {1'b0, cost} + (COST_W+1)'(c);
      res.cost_next = csum[COST_W] ? COST_MAX : csum[COST_W-1:0];
      if (nxt >= {1'b0, limit}) begin
        if (err == ERR_NONE) err = ERR_PC;
      end else begin
        res.pc_next = nxt[PC_W-1:0];
      end
    end
    res.err = err;
  end

endmodule

>>> sv/register_machine_execute_unit_core.sv
// register_machine_execute_unit_core: top level, register file and data memory with execute step
// depends on rmeu_pkg, rmeu_in_if, rmeu_out_if and rmeu_exec
//
//  channel  dir  handshake          beat
//  cmd      in   valid/ready        one instruction (opcode, registers, target, get value)
//  res      out  valid/ready        one result (pc, put, halted, error, cost)
//  cfg      in   cfg_we, no ready   program_length
//
// accept issues the register file and data memory reads into rf_a, rf_b and mem_q; the execute
// slot then executes and writes back once the result register is free, and cmd is not ready
// again until the execute slot empties; the result register lets the
// next instruction enter while the previous result waits
// after reset a clearing pass zeroes the register file and data memory, cmd not ready
// a stalled result stalls execution, cfg writes are taken at any time

module register_machine_execute_unit_core import rmeu_pkg::*; #(
  parameter int PROG_WORDS = 1024,
  parameter int MEM_WORDS  = 65536,
  parameter int REG_COUNT  = 8
) (
  input  logic              clk,
  input  logic              rst,
  rmeu_in_if.sink           cmd,
  rmeu_out_if.source        res,
  input  logic              cfg_we,
  input  logic [PLEN_W-1:0] cfg_wdata
);

  localparam int AW      = $clog2(MEM_WORDS);
  localparam int RA_W    = $clog2(REG_COUNT);
  localparam int LIM_CAP = (PROG_WORDS < 2048) ? PROG_WORDS : 2047;
  localparam logic [PC_W-1:0] LIMIT_CAP = PC_W'(LIM_CAP);
  localparam logic [AW-1:0]   CLR_LAST  = AW'(MEM_WORDS - 1);
  localparam logic [AW-1:0]   RF_LAST   = AW'(REG_COUNT);

  logic [DATA_W-1:0] rf [REG_COUNT];
  logic [DATA_W-1:0] dmem [MEM_WORDS];

  logic              clearing;
  logic [AW-1:0]     clr_idx;
  logic [PLEN_W-1:0] program_length;
  logic [PC_W-1:0]   pc;
  logic [COST_W-1:0] cost;
  logic              halt_flag;
  logic [DATA_W-1:0] r0;
  logic              ex_valid;
  instr_t            ex_ins;
  logic              ex_addr_ok;
  logic [DATA_W-1:0] rf_a;
  logic [DATA_W-1:0] rf_b;
  logic [DATA_W-1:0] mem_q;
  logic              res_valid;
  exec_t             out_reg;

  logic              accept;
  logic              ex_fire;
  logic              r0_in_range;
  logic [PC_W-1:0]   limit;
  instr_t            in_ins;
  exec_t             xr;
  logic              rf_we;
  logic [RA_W-1:0]   rf_wa;
  logic [DATA_W-1:0] rf_wd;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;

  assign cmd.ready   = !clearing && !ex_valid;
  assign accept      = cmd.valid && cmd.ready;
  assign ex_fire     = ex_valid && (!res_valid || res.ready);
  assign r0_in_range = !r0[DATA_W-1] && (r0 < DATA_W'(MEM_WORDS));
  assign limit       = (PC_W'(program_length) > LIMIT_CAP) ? LIMIT_CAP
                                                           : PC_W'(program_length);

  assign in_ins.opcode      = cmd.opcode;
  assign in_ins.reg_first   = cmd.reg_first;
  assign in_ins.reg_second  = cmd.reg_second;
  assign in_ins.jump_target = cmd.jump_target;
  assign in_ins.get_value   = cmd.get_value;

  rmeu_exec u_exec (
    .ins       (ex_ins),
    .halted    (halt_flag),
    .a         (rf_a),
    .b         (rf_b),
    .load_data (mem_q),
    .addr_ok   (ex_addr_ok),
    .pc        (pc),
    .limit     (limit),
    .cost      (cost),
    .res       (xr)
  );

  // write ports: the clearing pass owns them until it ends
  assign rf_we  = clearing ? (clr_idx < RF_LAST) : (ex_fire && xr.rf_we);
  assign rf_wa  = clearing ? clr_idx[RA_W-1:0] : RA_W'(xr.rf_addr);
  assign rf_wd  = clearing ? '0 : xr.rf_data;
  assign mem_we = clearing || (ex_fire && xr.mem_we);
  assign mem_wa = clearing ? clr_idx : r0[AW-1:0];
  assign mem_wd = clearing ? '0 : rf_a;

  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    if (accept) begin
      rf_a <= rf[RA_W'(cmd.reg_first)];
      rf_b <= rf[RA_W'(cmd.reg_second)];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) dmem[mem_wa] <= mem_wd;
    if (accept && r0_in_range) mem_q <= dmem[r0[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing       <= 1'b1;
      clr_idx        <= '0;
      program_length <= PLEN_RESET;
      pc             <= '0;
      cost           <= '0;
      halt_flag      <= 1'b0;
      r0             <= '0;
      ex_valid       <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + AW'(1);
        if (clr_idx == CLR_LAST) clearing <= 1'b0;
      end
      if (cfg_we) program_length <= cfg_wdata;
      if (accept) begin
        ex_valid <= 1'b1;
      end else if (ex_fire) begin
        ex_valid <= 1'b0;
      end
      if (ex_fire) begin
        pc        <= xr.pc_next;
        cost      <= xr.cost_next;
        halt_flag <= xr.halted;
        // shadow of register 0 feeds the memory address
        if (xr.rf_we && xr.rf_addr == '0) r0 <= xr.rf_data;
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_ins     <= in_ins;
      ex_addr_ok <= r0_in_range;
    end
    if (ex_fire) out_reg <= xr;
  end

  assign res.valid      = res_valid;
  assign res.next_pc    = out_reg.pc_next[OUT_PC_W-1:0];
  assign res.put_valid  = out_reg.put_valid;
  assign res.put_value  = out_reg.put_value;
  assign res.halted     = out_reg.halted;
  assign res.error_code = out_reg.err;
  assign res.cost_total = out_reg.cost_next;

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_flag |=> halt_flag)
    else $error("halt flag dropped without reset");

  a_mem_write_owner: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (clearing || ex_fire))
    else $error("data memory written outside clearing or execute");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (ex_valid && !accept))
    else $error("accepted instruction did not reach execute slot");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.error_code == ERR_NONE || res.error_code == ERR_PC ||
                   res.error_code == ERR_ADDR))
    else $error("bad error code on result");

endmodule
